### hw/rtl/pdm_pkg.sv
package pdm_pkg;

  // Default coordinate format: signed Q15.8
  localparam int COORD_WIDTH_DEF     = 24;
  localparam int COORD_FRAC_BITS_DEF = 8;

  // Unit factors are unsigned Q11.16
  localparam int UNIT_FRAC = 16;
  localparam int FACTOR_W  = 27;

  localparam int OUT_BITS = 28;
  localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

  // Square root: one result bit per cell, one bit of headroom above the output
  localparam int ROOT_W = OUT_BITS + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  // Register indexes
  localparam logic REG_UNIT_MODE   = 1'b0;
  localparam logic REG_METRIC_MODE = 1'b1;

  // Mode codes
  localparam logic [1:0] MODE_MAX     = 2'd2;
  localparam logic [1:0] UNIT_METRES  = 2'd0;
  localparam logic [1:0] UNIT_KM      = 2'd1;
  localparam logic [1:0] UNIT_MILES   = 2'd2;
  localparam logic [1:0] METRIC_TAXI  = 2'd0;
  localparam logic [1:0] METRIC_EUCL  = 2'd1;
  localparam logic [1:0] METRIC_CHEB  = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_METRES = 27'd65536;
  localparam logic [FACTOR_W-1:0] FACTOR_KM     = 27'd65536000;
  localparam logic [FACTOR_W-1:0] FACTOR_MILES  = 27'd105469706;

  // Item moving down the root chain
  typedef struct packed {
    logic [1:0]          metric;
    logic                sat;
    logic [OUT_BITS-1:0] other;
    logic [RAD_W-1:0]    rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
  } root_item_t;

  function automatic logic [FACTOR_W-1:0] unit_factor(input logic [1:0] unit);
    logic [FACTOR_W-1:0] f;
    unique case (unit)
      UNIT_KM:    f = FACTOR_KM;
      UNIT_MILES: f = FACTOR_MILES;
      default:    f = FACTOR_METRES;
    endcase
    return f;
  endfunction

endpackage

### hw/rtl/pdm_front.sv
module pdm_front import pdm_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic [1:0]                    unit_mode,
  input  logic [1:0]                    metric_mode,
  output logic                          out_valid,
  input  logic                          out_ready,
  output root_item_t                    out_item
);

  localparam int S      = COORD_FRAC_BITS + UNIT_FRAC;
  localparam int AX_W   = OUT_BITS + S;
  localparam int PROD_W = COORD_WIDTH + FACTOR_W;
  localparam int H      = (AX_W + 1) / 2;
  localparam int HI_W   = AX_W - H;
  localparam int SQ_W   = 2 * AX_W;

  // Stage handshake
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

  assign s5_ready = !out_valid || out_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid  <= in_valid;
      if (s2_ready) s2_valid  <= s1_valid;
      if (s3_ready) s3_valid  <= s2_valid;
      if (s4_ready) s4_valid  <= s3_valid;
      if (s5_ready) out_valid <= s4_valid;
    end
  end

  // Stage 1: absolute differences
  logic [COORD_WIDTH:0]   dx_raw, dy_raw;
  logic [COORD_WIDTH-1:0] s1_dx, s1_dy;
  logic [1:0]             s1_unit, s1_metric;

  assign dx_raw = {first_x[COORD_WIDTH-1], first_x} - {second_x[COORD_WIDTH-1], second_x};
  assign dy_raw = {first_y[COORD_WIDTH-1], first_y} - {second_y[COORD_WIDTH-1], second_y};

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_dx     <= dx_raw[COORD_WIDTH] ? COORD_WIDTH'(~dx_raw + 1'b1) : dx_raw[COORD_WIDTH-1:0];
      s1_dy     <= dy_raw[COORD_WIDTH] ? COORD_WIDTH'(~dy_raw + 1'b1) : dy_raw[COORD_WIDTH-1:0];
      s1_unit   <= unit_mode;
      s1_metric <= metric_mode;
    end
  end

  // Stage 2: scale to metres, flag out-of-range axes
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [AX_W-1:0]   ax_trunc, ay_trunc;
  logic              over;
  logic [AX_W-1:0]   s2_ax, s2_ay;
  logic              s2_sat;
  logic [1:0]        s2_metric;

  assign prod_x = PROD_W'(s1_dx) * PROD_W'(unit_factor(s1_unit));
  assign prod_y = PROD_W'(s1_dy) * PROD_W'(unit_factor(s1_unit));

  if (PROD_W > AX_W) begin : g_clip
    assign over     = (|prod_x[PROD_W-1:AX_W]) || (|prod_y[PROD_W-1:AX_W]);
    assign ax_trunc = prod_x[AX_W-1:0];
    assign ay_trunc = prod_y[AX_W-1:0];
  end else begin : g_noclip
    assign over     = 1'b0;
    assign ax_trunc = AX_W'(prod_x);
    assign ay_trunc = AX_W'(prod_y);
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_ax     <= ax_trunc;
      s2_ay     <= ay_trunc;
      s2_sat    <= over;
      s2_metric <= s1_metric;
    end
  end

  // Stage 3: half-word partial products; taxi and maximum results
  logic [HI_W-1:0]   x_hi, y_hi;
  logic [H-1:0]      x_lo, y_lo;
  logic [2*HI_W-1:0] x_hh, y_hh;
  logic [2*H-1:0]    x_ll, y_ll;
  logic [AX_W-1:0]   x_hl, y_hl;
  logic [AX_W:0]     taxi_sum;
  logic [AX_W-1:0]   larger;
  logic [OUT_BITS:0] taxi_whole;
  logic [OUT_BITS-1:0] other;

  assign x_hi = s2_ax[AX_W-1:H];
  assign x_lo = s2_ax[H-1:0];
  assign y_hi = s2_ay[AX_W-1:H];
  assign y_lo = s2_ay[H-1:0];
  assign x_hh = x_hi * x_hi;
  assign x_ll = x_lo * x_lo;
  assign x_hl = x_hi * x_lo;
  assign y_hh = y_hi * y_hi;
  assign y_ll = y_lo * y_lo;
  assign y_hl = y_hi * y_lo;

  assign taxi_sum   = {1'b0, s2_ax} + {1'b0, s2_ay};
  assign taxi_whole = taxi_sum[AX_W:S];
  assign larger     = (s2_ax > s2_ay) ? s2_ax : s2_ay;

  always_comb begin
    priority if (s2_sat) begin
      other = OUT_MAX;
    end else if (s2_metric == METRIC_CHEB) begin
      other = larger[AX_W-1:S];
    end else if (taxi_whole[OUT_BITS]) begin
      other = OUT_MAX;
    end else begin
      other = taxi_whole[OUT_BITS-1:0];
    end
  end

  logic [2*HI_W-1:0]   s3_x_hh, s3_y_hh;
  logic [2*H-1:0]      s3_x_ll, s3_y_ll;
  logic [AX_W-1:0]     s3_x_hl, s3_y_hl;
  logic                s3_sat;
  logic [1:0]          s3_metric;
  logic [OUT_BITS-1:0] s3_other;

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      s3_x_hh   <= x_hh;
      s3_x_ll   <= x_ll;
      s3_x_hl   <= x_hl;
      s3_y_hh   <= y_hh;
      s3_y_ll   <= y_ll;
      s3_y_hl   <= y_hl;
      s3_sat    <= s2_sat;
      s3_metric <= s2_metric;
      s3_other  <= other;
    end
  end

  // Stage 4: assemble the squares (high and low products do not overlap)
  logic [SQ_W-1:0]     s4_sx, s4_sy;
  logic                s4_sat;
  logic [1:0]          s4_metric;
  logic [OUT_BITS-1:0] s4_other;

  always_ff @(posedge clk) begin
    if (s3_valid && s4_ready) begin
      s4_sx     <= {s3_x_hh, s3_x_ll} + (SQ_W'(s3_x_hl) << (H + 1));
      s4_sy     <= {s3_y_hh, s3_y_ll} + (SQ_W'(s3_y_hl) << (H + 1));
      s4_sat    <= s3_sat;
      s4_metric <= s3_metric;
      s4_other  <= s3_other;
    end
  end

  // Stage 5: sum of squares, drop 2*S fraction bits for the root radicand
  logic [SQ_W:0] sq_sum;

  assign sq_sum = {1'b0, s4_sx} + {1'b0, s4_sy};

  always_ff @(posedge clk) begin
    if (s4_valid && s5_ready) begin
      out_item.metric <= s4_metric;
      out_item.sat    <= s4_sat;
      out_item.other  <= s4_other;
      out_item.rad    <= RAD_W'(sq_sum[SQ_W:2*S]);
      out_item.rem    <= '0;
      out_item.root   <= '0;
    end
  end

endmodule

### hw/rtl/pdm_root_cell.sv
module pdm_root_cell import pdm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  root_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output root_item_t out_item
);

  // One restoring square-root digit: bring down two radicand bits, try root*4+1
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;

  assign rem_sh = {in_item.rem[REM_W-3:0], in_item.rad[RAD_W-1:RAD_W-2]};
  assign trial  = {in_item.root, 2'b01};
  assign take   = rem_sh >= trial;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item.metric <= in_item.metric;
      out_item.sat    <= in_item.sat;
      out_item.other  <= in_item.other;
      out_item.rad    <= {in_item.rad[RAD_W-3:0], 2'b00};
      out_item.rem    <= take ? rem_sh - trial : rem_sh;
      out_item.root   <= {in_item.root[ROOT_W-2:0], take};
    end
  end

endmodule

### hw/rtl/planar_distance_metric.sv
// Each result passes through 5 front stages and 29 root cells, each holding one register.
// Throughput: one point pair per cycle while out_ready is high; every stage and cell
// holds its own item, so the pipeline fills behind a stalled output and only stops once
// all stages are full. Reset (synchronous, active high) empties the pipeline and sets
// unit_mode to metres and metric_mode to taxi distance.
module planar_distance_metric import pdm_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [1:0]                    cfg_data,
  // Point pair input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  // Distance output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [OUT_BITS-1:0]           distance_metres
);

  // Mode registers; a code above MODE_MAX is dropped so the stored value stays legal
  logic [1:0] unit_mode;
  logic [1:0] metric_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode   <= UNIT_METRES;
      metric_mode <= METRIC_TAXI;
    end else if (cfg_we && (cfg_data <= MODE_MAX)) begin
      unique case (cfg_index)
        REG_UNIT_MODE:   unit_mode   <= cfg_data;
        REG_METRIC_MODE: metric_mode <= cfg_data;
        default:         unit_mode   <= unit_mode;
      endcase
    end
  end

  // Front end: differences, unit scaling, taxi/max result and the sum of
  // squares. Its last register is the head of the root chain.
  logic       [ROOT_W:0] chain_valid;
  logic       [ROOT_W:0] chain_ready;
  root_item_t            chain_item [ROOT_W+1];

  pdm_front #(
    .COORD_WIDTH     (COORD_WIDTH),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .first_x     (first_x),
    .first_y     (first_y),
    .second_x    (second_x),
    .second_y    (second_y),
    .unit_mode   (unit_mode),
    .metric_mode (metric_mode),
    .out_valid   (chain_valid[0]),
    .out_ready   (chain_ready[0]),
    .out_item    (chain_item[0])
  );

  // Root chain: each cell resolves one bit of the whole-metre Euclidean distance,
  // most significant first. Taxi and maximum results ride along unchanged so all
  // metrics share the same latency and results leave in order.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    pdm_root_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  // The last cell's register is the output register
  root_item_t last;

  assign last                = chain_item[ROOT_W];
  assign out_valid           = chain_valid[ROOT_W];
  assign chain_ready[ROOT_W] = out_ready;

  // Saturate: an axis past range, or a root with the headroom bit set
  always_comb begin
    priority if (last.sat) begin
      distance_metres = OUT_MAX;
    end else if (last.metric == METRIC_EUCL) begin
      distance_metres = last.root[ROOT_W-1] ? OUT_MAX : last.root[OUT_BITS-1:0];
    end else begin
      distance_metres = last.other;
    end
  end

endmodule
